// File: sv/lcc_pkg.sv
`default_nettype none

package lcc_pkg;

  localparam int MAX_TAPS   = 32;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int LEN_W      = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = 38;
  localparam int KLEN_W     = 6;
  localparam int TIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CORRELATE_MODE = CFG_IDX_W'(1);

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // control for the delay-line cells
  typedef struct packed {
    logic shift_in;
    logic rotate;
    logic clear;
  } cell_ctl_t;

  // control for the tap store and multiply-accumulate
  typedef struct packed {
    logic              start;
    logic              tap_wr;
    logic [TAP_AW-1:0] wr_addr;
    sample_t           wr_data;
    logic              step;
    logic [TAP_AW-1:0] rd_addr;
    sample_t           sample;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: sv/lcc_cell.sv
`default_nettype none

module lcc_cell
  import lcc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire sample_t   left,
  input  wire sample_t   right,
  output sample_t        q
);

  // one delay-line position; shifts in from the left, rotates from the right
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.shift_in) begin
      q <= left;
    end else if (ctl.rotate) begin
      q <= right;
    end
  end

endmodule

`default_nettype wire

// File: sv/lcc_mac.sv
`default_nettype none

module lcc_mac
  import lcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_ctl_t          ctl,
  output logic signed [ACC_W-1:0] acc
);

  sample_t                    taps [MAX_TAPS];
  sample_t                    tap_q;
  sample_t                    smp_q;
  logic                       v1;
  logic                       v2;
  logic signed [PROD_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (ctl.tap_wr) begin
      taps[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    tap_q <= taps[ctl.rd_addr];
    smp_q <= ctl.sample;
    prod  <= tap_q * smp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.step;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

`default_nettype wire

// File: sv/linear_convolution_correlation_unit.sv
`default_nettype none

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------------
// input    | in        | in_valid / in_stall     | req_type, tap_index, sample_value,
//          |           |                         | last_sample
// output   | out       | out_valid / out_stall   | conv_value, run_last
// config   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a tap item never occupies the engine; each output of a sample item is formed by a full
// rotation of the cell chain, the multiply-accumulate drain (S_DRAIN_A, S_DRAIN_B) and a
// hand-over in S_DONE, a last sample with L taps gives L outputs, the last L-1 of them from
// zero inputs, and the input is free again in the same cycle as the final output is valid
// reset clears the delay line, the output valid and the registers
// (kernel_length 1, convolution); kernel taps are undefined until written
// a held output stall only holds the engine once its next result is ready

module linear_convolution_correlation_unit
  import lcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [TIDX_W-1:0]     tap_index,
  input  wire sample_t               sample_value,
  input  wire logic                  last_sample,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [ACC_W-1:0]    conv_value,
  output logic                       run_last,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTATE,
    S_DRAIN_A,
    S_DRAIN_B,
    S_DONE
  } state_t;

  state_t                  state;
  logic [TAP_AW-1:0]       k;          // rotation step, also delay position at the head
  logic [LEN_W-1:0]        tail_left;  // zero-input outputs still owed after a last sample
  logic                    last_run;

  logic [KLEN_W-1:0]       kernel_length;
  logic                    correlate_mode;
  logic [LEN_W-1:0]        len;

  logic                    in_acc;
  logic                    smp_acc;
  logic                    out_free;
  logic                    tail_go;

  cell_ctl_t               cell_ctl;
  mac_ctl_t                mac_ctl;
  sample_t                 x_in;
  sample_t                 w [MAX_TAPS];
  logic signed [ACC_W-1:0] acc;
  logic [LEN_W-1:0]        rev_idx;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_length  <= KLEN_W'(1);
      correlate_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KERNEL_LENGTH:  kernel_length  <= cfg_data[KLEN_W-1:0];
        REG_CORRELATE_MODE: correlate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective length: zero reads as one, oversize saturates
  always_comb begin
    priority if (kernel_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(kernel_length) > MAX_TAPS) begin
      len = LEN_W'(MAX_TAPS);
    end else begin
      len = LEN_W'(kernel_length);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (req_type == REQ_SAMPLE);
  assign out_free = !out_valid || !out_stall;
  assign tail_go  = (state == S_DONE) && out_free && (tail_left != '0);

  // new sample enters at the head; tail outputs feed zeros
  assign x_in = (state == S_IDLE) ? sample_value : '0;

  always_comb begin
    cell_ctl.shift_in = smp_acc || tail_go;
    cell_ctl.rotate   = (state == S_ROTATE);
    cell_ctl.clear    = (state == S_DONE) && out_free && (tail_left == '0) && last_run;
  end

  // correlation reads taps back to front
  assign rev_idx = len - LEN_W'(1) - LEN_W'(k);

  always_comb begin
    mac_ctl.start   = smp_acc || tail_go;
    mac_ctl.tap_wr  = in_acc && (req_type == REQ_TAP) && (32'(tap_index) < MAX_TAPS);
    mac_ctl.wr_addr = TAP_AW'(tap_index);
    mac_ctl.wr_data = sample_value;
    mac_ctl.step    = (state == S_ROTATE) && (LEN_W'(k) < len);
    mac_ctl.rd_addr = correlate_mode ? TAP_AW'(rev_idx) : k;
    mac_ctl.sample  = w[0];
  end

  // chain of delay cells: cell 0 is the newest sample, the chain rotates
  // towards the head once per tap position during accumulation
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    lcc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (cell_ctl),
      .left  ((i == 0) ? x_in : w[(i == 0) ? 0 : i - 1]),
      .right (w[(i + 1) % MAX_TAPS]),
      .q     (w[i])
    );
  end

  lcc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .acc (acc)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      tail_left <= '0;
      last_run  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a finished sum loads the output register, a taken item empties it
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (smp_acc) begin
            state     <= S_ROTATE;
            k         <= '0;
            last_run  <= last_sample;
            tail_left <= last_sample ? (len - LEN_W'(1)) : '0;
          end
        end
        S_ROTATE: begin
          k <= k + TAP_AW'(1);
          if (k == TAP_AW'(MAX_TAPS - 1)) begin
            state <= S_DRAIN_A;
          end
        end
        S_DRAIN_A: state <= S_DRAIN_B;
        S_DRAIN_B: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            conv_value <= acc;
            run_last   <= last_run && (tail_left == '0);
            if (tail_left != '0) begin
              tail_left <= tail_left - LEN_W'(1);
              k         <= '0;
              state     <= S_ROTATE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/lcc_checker.sv
`default_nettype none

module lcc_checker
  import lcc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  req_type,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic signed [ACC_W-1:0] conv_value,
  input wire logic                  run_last,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(conv_value) && $stable(run_last))
    else $error("stalled result changed");

  // reset leaves nothing pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state after reset not clean");

  // a tap item never occupies the engine
  a_tap_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_TAP |=> !in_stall)
    else $error("tap item held the input");

  // a sample item occupies the engine once it is taken
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_SAMPLE |=> in_stall ##1 in_stall)
    else $error("sample item did not occupy the engine");

  // configuration never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind linear_convolution_correlation_unit lcc_checker u_lcc_checker (.*);

`default_nettype wire

// File: tb/linear_convolution_correlation_unit_tb.sv
`timescale 1ns / 1ps

import lcc_pkg::*;

typedef struct {
  logic signed [ACC_W-1:0] value;
  logic                    last;
} conv_result_t;

// tracks kernel, delay line and settings, and the outputs still owed by the block
class conv_scoreboard;
  sample_t             taps [MAX_TAPS];
  sample_t             history [MAX_TAPS-1];
  logic [KLEN_W-1:0]   klen;
  logic                corr;
  conv_result_t        owed_outputs [$];
  int                  errors;

  function new();
    foreach (taps[k]) taps[k] = '0;
    foreach (history[k]) history[k] = '0;
    klen = KLEN_W'(1);
    corr = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_KERNEL_LENGTH) klen = data[KLEN_W-1:0];
    else if (idx == REG_CORRELATE_MODE) corr = data[0];
  endfunction

  function int taps_in_use();
    int l;
    l = klen;
    if (l == 0) l = 1;
    if (l > MAX_TAPS) l = MAX_TAPS;
    return l;
  endfunction

  // push one sample into the delay line and form its output
  function logic signed [ACC_W-1:0] shift_and_sum(sample_t x);
    sample_t win [MAX_TAPS];
    longint  acc;
    int      len;
    int      t;
    len = taps_in_use();
    acc = 0;
    win[0] = x;
    for (int k = 1; k < MAX_TAPS; k++) win[k] = history[k-1];
    for (int k = 0; k < len; k++) begin
      t = corr ? len - 1 - k : k;
      acc += longint'(taps[t]) * longint'(win[k]);
    end
    for (int k = 0; k < MAX_TAPS - 1; k++) history[k] = win[k];
    return acc[ACC_W-1:0];
  endfunction

  function void note_item(logic rt, logic [TIDX_W-1:0] idx, sample_t val, logic last);
    conv_result_t r;
    int           len;
    if (rt == REQ_TAP) begin
      taps[idx] = val;
      return;
    end
    len = taps_in_use();
    r.value = shift_and_sum(val);
    r.last = last && (len == 1);
    owed_outputs.push_back(r);
    if (last) begin
      for (int n = 1; n < len; n++) begin
        r.value = shift_and_sum('0);
        r.last = (n + 1 == len);
        owed_outputs.push_back(r);
      end
      foreach (history[k]) history[k] = '0;
    end
  endfunction

  function void check_result(logic signed [ACC_W-1:0] value, logic last);
    conv_result_t r;
    if (owed_outputs.size() == 0) begin
      $error("conv_value: expected none, actual %0d", value);
      errors++;
      return;
    end
    r = owed_outputs.pop_front();
    if (value !== r.value) begin
      $error("conv_value: expected %0d, actual %0d", r.value, value);
      errors++;
    end
    if (last !== r.last) begin
      $error("run_last: expected %0b, actual %0b", r.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return owed_outputs.size();
  endfunction
endclass

module linear_convolution_correlation_unit_tb;

  // cycles without any handshake before the run is declared hung; allows for the forming
  // of one output plus a long run of receiver stalls
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 120;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    req_type = REQ_TAP;
  logic [TIDX_W-1:0]       tap_index = '0;
  sample_t                 sample_value = '0;
  logic                    last_sample = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] conv_value;
  logic                    run_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // idle chances in percent for the two sides, changed as the run goes on
  int send_idle_pct = 18;
  int recv_idle_pct = 75;
  int quiet_cycles = 0;

  conv_scoreboard sb = new();

  linear_convolution_correlation_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .tap_index    (tap_index),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .conv_value   (conv_value),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check each accepted output, then pick the stall for the next edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(conv_value, run_last);
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // hang watchdog: any handshake on any channel resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one item and hold it until accepted; valid stays high afterwards so
  // the next call can follow straight on without a bubble
  task automatic send_item(input logic rt, input logic [TIDX_W-1:0] idx,
                           input sample_t val, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    tap_index <= idx;
    sample_value <= val;
    last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(rt, idx, val, last);
  endtask

  // drop valid, wait for every owed output, then let the engine settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (MAX_TAPS + 8) @(posedge clk);
  endtask

  // write both registers back to back; only called with the block idle
  task automatic configure(input logic [CFG_DATA_W-1:0] len, input logic mode);
    logic [CFG_IDX_W-1:0]  idx [2];
    logic [CFG_DATA_W-1:0] data [2];
    idx[0] = REG_KERNEL_LENGTH;
    data[0] = len;
    idx[1] = REG_CORRELATE_MODE;
    data[1] = CFG_DATA_W'(mode);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= idx[i];
      cfg_data <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                    sent;
    int                    phase_len;
    logic [CFG_DATA_W-1:0] len;
    sample_t               val;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // load every tap so no unwritten tap is ever read; extremes at both ends
    for (int k = 0; k < MAX_TAPS; k++) begin
      val = (k == 0) ? sample_t'(-32768) :
            (k == MAX_TAPS - 1) ? sample_t'(32767) : sample_t'($urandom);
      send_item(REQ_TAP, TIDX_W'(k), val, 1'b0);
    end

    // single tap after reset: sample extremes and a last sample with no tail
    send_item(REQ_SAMPLE, TIDX_W'($urandom), -16'sd32768, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'($urandom), 16'sd32767, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'($urandom), 16'sd0, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'($urandom), -16'sd1, 1'b1);
    // tap write with the last flag set: flag is ignored, no output
    send_item(REQ_TAP, TIDX_W'(1), -16'sd32768, 1'b1);
    wait_idle();

    // short kernel, correlation then convolution over the same signal
    configure(CFG_DATA_W'(4), 1'b1);
    send_item(REQ_SAMPLE, TIDX_W'(0), 16'sd32767, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(31), -16'sd32768, 1'b1);
    wait_idle();
    configure(CFG_DATA_W'(4), 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(0), 16'sd32767, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(31), -16'sd32768, 1'b1);
    wait_idle();

    // zero length behaves as one tap
    configure(CFG_DATA_W'(0), 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(5), 16'sd12345, 1'b1);
    wait_idle();

    // oversized length saturates to the full kernel, full tail flush
    configure(CFG_DATA_W'(63), 1'b1);
    send_item(REQ_SAMPLE, TIDX_W'(9), -16'sd32768, 1'b1);
    wait_idle();
    configure(CFG_DATA_W'(MAX_TAPS), 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(17), -16'sd32768, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(3), 16'sd32767, 1'b1);
    wait_idle();

    // length change in the middle of a signal keeps the history
    configure(CFG_DATA_W'(3), 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(0), 16'sd1000, 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(0), -16'sd2000, 1'b0);
    wait_idle();
    configure(CFG_DATA_W'(6), 1'b0);
    send_item(REQ_SAMPLE, TIDX_W'(0), 16'sd3000, 1'b1);
    wait_idle();

    // random phases; a phase may end mid-signal so the next setting applies to it
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 75;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // mostly short kernels, now and then the edges of the range
      if ($urandom_range(9) < 7) begin
        len = CFG_DATA_W'($urandom_range(6, 1));
      end else begin
        case ($urandom_range(4))
          0: len = CFG_DATA_W'(0);
          1: len = CFG_DATA_W'(MAX_TAPS);
          2: len = CFG_DATA_W'(MAX_TAPS + 1);
          3: len = CFG_DATA_W'(63);
          default: len = CFG_DATA_W'($urandom_range(MAX_TAPS, 7));
        endcase
      end
      configure(len, 1'($urandom));

      phase_len = $urandom_range(24, 8);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(99) < 15) begin
          send_item(REQ_TAP, TIDX_W'($urandom), sample_t'($urandom), 1'($urandom));
        end else begin
          case ($urandom_range(9))
            0: val = -16'sd32768;
            1: val = 16'sd32767;
            default: val = sample_t'($urandom);
          endcase
          send_item(REQ_SAMPLE, TIDX_W'($urandom), val, $urandom_range(5) == 0);
        end
        sent++;
      end
      wait_idle();
    end

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/lcc_pkg.sv
sv/lcc_cell.sv
sv/lcc_mac.sv
sv/linear_convolution_correlation_unit.sv
sv/lcc_checker.sv
tb/linear_convolution_correlation_unit_tb.sv
